### sv/size_with_unit_string_parser_macros.svh
// assertion macros used by the checker file
`ifndef SIZE_WITH_UNIT_STRING_PARSER_MACROS_SVH
`define SIZE_WITH_UNIT_STRING_PARSER_MACROS_SVH

// property that holds in the same cycle as its condition
`define SWUP_CHECK_NOW(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("swup check failed: same-cycle property");

// property that holds in the cycle after its condition
`define SWUP_CHECK_NEXT(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("swup check failed: next-cycle property");

// property that also holds across reset
`define SWUP_CHECK_RESET(label, ante, cons) \
  label: assert property (@(posedge clk) (ante) |=> (cons)) \
    else $error("swup check failed: reset property");

`endif

### sv/swup_pkg.sv
package swup_pkg;

  // default depth of the token queue between front and back
  localparam int QueueDepth = 4;

  // result status codes
  typedef enum logic [2:0] {
    ST_OK           = 3'd0,
    ST_EMPTY        = 3'd1,
    ST_NEGATIVE     = 3'd2,
    ST_NO_DIGITS    = 3'd3,
    ST_NUM_OVERFLOW = 3'd4,
    ST_TOO_LARGE    = 3'd5,
    ST_BAD_UNIT     = 3'd6
  } status_t;

  // parser phase
  typedef enum logic [1:0] {
    PH_LEAD,
    PH_DIGITS,
    PH_UNIT,
    PH_FAILED
  } phase_t;

  // byte class found by the front
  typedef enum logic [1:0] {
    TK_SPACE,
    TK_MINUS,
    TK_DIGIT,
    TK_OTHER
  } kind_t;

  // unit scale
  typedef enum logic [1:0] {
    SC_BYTE,
    SC_KIB,
    SC_MIB,
    SC_GIB
  } scale_t;

  typedef struct packed {
    logic [7:0] char_in;
    logic       is_last;
    logic       is_empty;
  } in_req_t;

  typedef struct packed {
    logic [63:0] size_value;
    status_t     status;
  } out_req_t;

  // classified byte: digit value for digits, upper-case byte otherwise
  typedef struct packed {
    kind_t      kind;
    logic [7:0] code;
    logic       is_last;
    logic       is_empty;
  } token_t;

  // largest value that can still take another digit
  localparam logic [63:0] AccLimit = 64'h1999_9999_9999_9999;
  localparam logic [3:0]  LimitDigit = 4'd5;

  localparam logic [7:0] CharZero  = 8'h30;
  localparam logic [7:0] CharNine  = 8'h39;
  localparam logic [7:0] CharMinus = 8'h2D;
  localparam logic [7:0] CharLowA  = 8'h61;
  localparam logic [7:0] CharLowZ  = 8'h7A;
  localparam logic [7:0] CharSpace = 8'h20;
  localparam logic [7:0] CharTab   = 8'h09;
  localparam logic [7:0] CharCr    = 8'h0D;
  localparam logic [7:0] CharB     = 8'h42;
  localparam logic [7:0] CharK     = 8'h4B;
  localparam logic [7:0] CharM     = 8'h4D;
  localparam logic [7:0] CharG     = 8'h47;
  localparam logic [7:0] CaseGap   = 8'h20;

endpackage

### sv/size_with_unit_string_parser.sv
// Size string parser with unit suffix.
// Input channel in_valid/in_stall/in_data carries one byte of the string per
// request, with is_last on the final byte, or is_empty for an empty string.
// Output channel out_valid/out_stall/out_data carries one result per string:
// size_value in bytes and status (ok or the first error found).
// One byte is taken per cycle, sustained while in_stall is low, with strings back to back.
// The last byte is written into the queue and popped into the output register,
// which raises out_valid; this is delayed while the queue holds bytes from an earlier stall.
// The front classifies each byte into a token and writes it into a queue of
// QUEUE_DEPTH entries; the back pops one token per cycle, runs the
// multiply-by-ten-and-add and unit match, and loads the output register.
// While out_stall is high the result holds, the back stops popping and the
// queue fills; in_stall rises once the queue is full.
// Reset empties the queue, drops any pending result and returns the parser
// to the leading whitespace phase; no request is lost after reset ends.
module size_with_unit_string_parser #(
  parameter int QUEUE_DEPTH = swup_pkg::QueueDepth
) (
  input  logic               clk,
  input  logic               rst,
  input  logic               in_valid,
  output logic               in_stall,
  input  swup_pkg::in_req_t  in_data,
  output logic               out_valid,
  input  logic               out_stall,
  output swup_pkg::out_req_t out_data
);

  logic             full;
  logic             push;
  swup_pkg::token_t push_token;
  logic             pop;
  logic             pop_valid;
  swup_pkg::token_t pop_token;

  // byte classification
  swup_front u_front (
    .in_valid   (in_valid),
    .in_stall   (in_stall),
    .in_data    (in_data),
    .full       (full),
    .push       (push),
    .push_token (push_token)
  );

  // token queue
  swup_queue #(
    .DEPTH (QUEUE_DEPTH)
  ) u_queue (
    .clk        (clk),
    .rst        (rst),
    .push       (push),
    .push_token (push_token),
    .full       (full),
    .pop        (pop),
    .pop_valid  (pop_valid),
    .pop_token  (pop_token)
  );

  // parse and result
  swup_back u_back (
    .clk       (clk),
    .rst       (rst),
    .pop_valid (pop_valid),
    .pop_token (pop_token),
    .pop       (pop),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_data  (out_data)
  );

endmodule

### sv/swup_front.sv
module swup_front (
  input  logic              in_valid,
  output logic              in_stall,
  input  swup_pkg::in_req_t in_data,
  input  logic              full,
  output logic              push,
  output swup_pkg::token_t  push_token
);

  logic [7:0] c;

  // accept whenever the queue has room
  assign push     = in_valid && !full;
  assign in_stall = full;
  assign c        = in_data.char_in;

  // classify the byte and fold letter case
  always_comb begin
    push_token.is_last  = in_data.is_last;
    push_token.is_empty = in_data.is_empty;
    push_token.code     = c;
    if (c == swup_pkg::CharSpace || (c >= swup_pkg::CharTab && c <= swup_pkg::CharCr)) begin
      push_token.kind = swup_pkg::TK_SPACE;
    end else if (c == swup_pkg::CharMinus) begin
      push_token.kind = swup_pkg::TK_MINUS;
    end else if (c >= swup_pkg::CharZero && c <= swup_pkg::CharNine) begin
      push_token.kind = swup_pkg::TK_DIGIT;
      push_token.code = c - swup_pkg::CharZero;
    end else begin
      push_token.kind = swup_pkg::TK_OTHER;
      if (c >= swup_pkg::CharLowA && c <= swup_pkg::CharLowZ) begin
        push_token.code = c - swup_pkg::CaseGap;
      end
    end
  end

endmodule

### sv/swup_queue.sv
module swup_queue #(
  parameter int DEPTH = swup_pkg::QueueDepth
) (
  input  logic             clk,
  input  logic             rst,
  input  logic             push,
  input  swup_pkg::token_t push_token,
  output logic             full,
  input  logic             pop,
  output logic             pop_valid,
  output swup_pkg::token_t pop_token
);

  localparam int PtrW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CntW = $clog2(DEPTH + 1);

  swup_pkg::token_t entries [DEPTH];
  logic [PtrW-1:0]  wr_ptr;
  logic [PtrW-1:0]  rd_ptr;
  logic [CntW-1:0]  count;

  assign full      = (count == CntW'(DEPTH));
  assign pop_valid = (count != '0);
  assign pop_token = entries[rd_ptr];

  // pointers and fill count
  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) begin
        wr_ptr <= (wr_ptr == PtrW'(DEPTH - 1)) ? '0 : wr_ptr + 1'b1;
      end
      if (pop) begin
        rd_ptr <= (rd_ptr == PtrW'(DEPTH - 1)) ? '0 : rd_ptr + 1'b1;
      end
      if (push && !pop) begin
        count <= count + 1'b1;
      end else if (pop && !push) begin
        count <= count - 1'b1;
      end
    end
  end

  // token storage
  always_ff @(posedge clk) begin
    if (push) begin
      entries[wr_ptr] <= push_token;
    end
  end

endmodule

### sv/swup_back.sv
module swup_back (
  input  logic               clk,
  input  logic               rst,
  input  logic               pop_valid,
  input  swup_pkg::token_t   pop_token,
  output logic               pop,
  output logic               out_valid,
  input  logic               out_stall,
  output swup_pkg::out_req_t out_data
);

  swup_pkg::phase_t  phase;
  swup_pkg::phase_t  phase_byte;
  swup_pkg::phase_t  phase_next;
  logic [63:0]       accumulator;
  logic [63:0]       accumulator_next;
  logic              number_overflowed;
  logic              number_overflowed_next;
  swup_pkg::status_t early_error;
  swup_pkg::status_t early_error_next;
  logic [7:0]        unit_letters [2];
  logic [7:0]        unit_letters_next [2];
  logic [1:0]        unit_count;
  logic [1:0]        unit_count_next;
  logic              unit_invalid;
  logic              unit_invalid_next;
  logic              unit_closed;
  logic              unit_closed_next;

  logic              ends;
  logic              emit;
  logic              take_digit;
  logic              take_unit;
  logic [63:0]       acc_b;
  logic              ovf_b;
  swup_pkg::status_t err_b;
  logic [7:0]        let_b [2];
  logic [1:0]        cnt_b;
  logic              inv_b;
  logic              cls_b;
  logic              scale_ok;
  swup_pkg::scale_t  scale;
  swup_pkg::out_req_t result;

  assign pop  = pop_valid && (!out_valid || !out_stall);
  assign ends = pop_token.is_empty || pop_token.is_last;
  assign emit = pop && ends;

  // phase after this byte, then back to leading whitespace at string end
  always_comb begin
    phase_byte = phase;
    case (phase)
      swup_pkg::PH_LEAD: begin
        case (pop_token.kind)
          swup_pkg::TK_SPACE: phase_byte = swup_pkg::PH_LEAD;
          swup_pkg::TK_DIGIT: phase_byte = swup_pkg::PH_DIGITS;
          default:            phase_byte = swup_pkg::PH_FAILED;
        endcase
      end
      swup_pkg::PH_DIGITS: begin
        if (pop_token.kind != swup_pkg::TK_DIGIT) begin
          phase_byte = swup_pkg::PH_UNIT;
        end
      end
      default: phase_byte = phase;
    endcase
    if (!pop) begin
      phase_next = phase;
    end else if (ends) begin
      phase_next = swup_pkg::PH_LEAD;
    end else begin
      phase_next = phase_byte;
    end
  end

  // per-byte datapath, unit check and result
  always_comb begin
    take_digit = (pop_token.kind == swup_pkg::TK_DIGIT) &&
                 (phase == swup_pkg::PH_LEAD || phase == swup_pkg::PH_DIGITS);
    take_unit  = (phase == swup_pkg::PH_UNIT) ||
                 (phase == swup_pkg::PH_DIGITS && pop_token.kind != swup_pkg::TK_DIGIT);

    // early errors from the first byte after leading whitespace
    err_b = early_error;
    if (phase == swup_pkg::PH_LEAD) begin
      if (pop_token.kind == swup_pkg::TK_MINUS) begin
        err_b = swup_pkg::ST_NEGATIVE;
      end else if (pop_token.kind == swup_pkg::TK_OTHER) begin
        err_b = swup_pkg::ST_NO_DIGITS;
      end
    end

    // multiply by ten and add, hold on overflow
    acc_b = accumulator;
    ovf_b = number_overflowed;
    if (take_digit) begin
      if (accumulator > swup_pkg::AccLimit ||
          (accumulator == swup_pkg::AccLimit && pop_token.code[3:0] > swup_pkg::LimitDigit)) begin
        ovf_b = 1'b1;
      end else begin
        acc_b = {accumulator[60:0], 3'b000} + {accumulator[62:0], 1'b0} +
                {60'd0, pop_token.code[3:0]};
      end
    end

    // unit letters with whitespace trim
    let_b = unit_letters;
    cnt_b = unit_count;
    inv_b = unit_invalid;
    cls_b = unit_closed;
    if (take_unit) begin
      if (pop_token.kind == swup_pkg::TK_SPACE) begin
        if (unit_count != 2'd0) begin
          cls_b = 1'b1;
        end
      end else if (unit_closed || unit_count[1]) begin
        inv_b = 1'b1;
      end else begin
        let_b[unit_count[0]] = pop_token.code;
        cnt_b = unit_count + 2'd1;
      end
    end

    // unit to scale
    scale    = swup_pkg::SC_BYTE;
    scale_ok = 1'b1;
    if (cnt_b == 2'd1) begin
      scale_ok = (let_b[0] == swup_pkg::CharB);
    end else if (cnt_b == 2'd2) begin
      if (let_b[0] == swup_pkg::CharK) begin
        scale = swup_pkg::SC_KIB;
      end else if (let_b[0] == swup_pkg::CharM) begin
        scale = swup_pkg::SC_MIB;
      end else if (let_b[0] == swup_pkg::CharG) begin
        scale = swup_pkg::SC_GIB;
      end else begin
        scale_ok = 1'b0;
      end
      if (let_b[1] != swup_pkg::CharB) begin
        scale_ok = 1'b0;
      end
    end

    // scaled value and too-large check
    result.size_value = 64'd0;
    result.status     = swup_pkg::ST_OK;
    case (scale)
      swup_pkg::SC_KIB: begin
        if (acc_b[63:54] != '0) begin
          result.status = swup_pkg::ST_TOO_LARGE;
        end else begin
          result.size_value = {acc_b[53:0], 10'd0};
        end
      end
      swup_pkg::SC_MIB: begin
        if (acc_b[63:44] != '0) begin
          result.status = swup_pkg::ST_TOO_LARGE;
        end else begin
          result.size_value = {acc_b[43:0], 20'd0};
        end
      end
      swup_pkg::SC_GIB: begin
        if (acc_b[63:34] != '0) begin
          result.status = swup_pkg::ST_TOO_LARGE;
        end else begin
          result.size_value = {acc_b[33:0], 30'd0};
        end
      end
      default: result.size_value = acc_b;
    endcase

    // error order overrides the scaled result
    if (pop_token.is_empty) begin
      result.status = swup_pkg::ST_EMPTY;
    end else if (err_b != swup_pkg::ST_OK) begin
      result.status = err_b;
    end else if (phase_byte == swup_pkg::PH_LEAD) begin
      result.status = swup_pkg::ST_NO_DIGITS;
    end else if (ovf_b) begin
      result.status = swup_pkg::ST_NUM_OVERFLOW;
    end else if (inv_b || !scale_ok) begin
      result.status = swup_pkg::ST_BAD_UNIT;
    end
    if (result.status != swup_pkg::ST_OK) begin
      result.size_value = 64'd0;
    end

    // next state: hold, clear at string end, or take the byte
    accumulator_next       = accumulator;
    number_overflowed_next = number_overflowed;
    early_error_next       = early_error;
    unit_letters_next      = unit_letters;
    unit_count_next        = unit_count;
    unit_invalid_next      = unit_invalid;
    unit_closed_next       = unit_closed;
    if (pop) begin
      if (ends) begin
        accumulator_next       = 64'd0;
        number_overflowed_next = 1'b0;
        early_error_next       = swup_pkg::ST_OK;
        unit_letters_next[0]   = 8'd0;
        unit_letters_next[1]   = 8'd0;
        unit_count_next        = 2'd0;
        unit_invalid_next      = 1'b0;
        unit_closed_next       = 1'b0;
      end else begin
        accumulator_next       = acc_b;
        number_overflowed_next = ovf_b;
        early_error_next       = err_b;
        unit_letters_next      = let_b;
        unit_count_next        = cnt_b;
        unit_invalid_next      = inv_b;
        unit_closed_next       = cls_b;
      end
    end
  end

  // parser state
  always_ff @(posedge clk) begin
    if (rst) begin
      phase             <= swup_pkg::PH_LEAD;
      accumulator       <= 64'd0;
      number_overflowed <= 1'b0;
      early_error       <= swup_pkg::ST_OK;
      unit_letters[0]   <= 8'd0;
      unit_letters[1]   <= 8'd0;
      unit_count        <= 2'd0;
      unit_invalid      <= 1'b0;
      unit_closed       <= 1'b0;
    end else begin
      phase             <= phase_next;
      accumulator       <= accumulator_next;
      number_overflowed <= number_overflowed_next;
      early_error       <= early_error_next;
      unit_letters      <= unit_letters_next;
      unit_count        <= unit_count_next;
      unit_invalid      <= unit_invalid_next;
      unit_closed       <= unit_closed_next;
    end
  end

  // output register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else begin
      out_valid <= emit || (out_valid && out_stall);
    end
  end

  always_ff @(posedge clk) begin
    if (emit) begin
      out_data <= result;
    end
  end

endmodule

### sv/swup_checker.sv
`include "size_with_unit_string_parser_macros.svh"

module swup_checker (
  input logic               clk,
  input logic               rst,
  input logic               in_valid,
  input logic               in_stall,
  input swup_pkg::in_req_t  in_data,
  input logic               out_valid,
  input logic               out_stall,
  input swup_pkg::out_req_t out_data
);

  // a failed parse never carries a size
  `SWUP_CHECK_NOW(a_err_zero, out_valid && out_data.status != swup_pkg::ST_OK, out_data.size_value == 64'd0)

  // a stalled result holds
  `SWUP_CHECK_NEXT(a_out_hold, out_valid && out_stall, out_valid && $stable(out_data))

  // reset drops the result and empties the queue
  `SWUP_CHECK_RESET(a_reset_clear, rst, !out_valid && !in_stall)

  // a stalled request holds
  `SWUP_CHECK_NEXT(a_in_hold, in_valid && in_stall, in_valid && $stable(in_data))

endmodule

bind size_with_unit_string_parser swup_checker u_swup_checker (
  .clk       (clk),
  .rst       (rst),
  .in_valid  (in_valid),
  .in_stall  (in_stall),
  .in_data   (in_data),
  .out_valid (out_valid),
  .out_stall (out_stall),
  .out_data  (out_data)
);
